@@ hw/rtl/ahv_pkg.sv @@
// ----------------------------------------------------------------------------
// Archive header validator package
// Shared types, constants and the byte-wise CRC-32 update function.
// ----------------------------------------------------------------------------
package ahv_pkg;

  // Positions within the 18-byte header.
  localparam int unsigned POS_W = 5;
  typedef logic [POS_W-1:0] ahv_pos_t;

  localparam ahv_pos_t MAGIC_LEN    = 5'd3;
  localparam ahv_pos_t CRC_SPAN     = 5'd14;
  localparam ahv_pos_t OFF_BASE     = 5'd6;
  localparam ahv_pos_t CNT_BASE     = 5'd10;
  localparam ahv_pos_t SCRC_BASE    = 5'd14;
  localparam ahv_pos_t HDR_LAST_POS = 5'd17;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Magic bytes, ASCII "T", "C", "F".
  localparam logic [7:0] MAGIC_B0 = 8'h54;
  localparam logic [7:0] MAGIC_B1 = 8'h43;
  localparam logic [7:0] MAGIC_B2 = 8'h46;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FORMAT = 2'd1,
    ST_CRC    = 2'd2
  } ahv_status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } ahv_in_t;

  typedef struct packed {
    ahv_status_t status;
    logic [31:0] idx_ofs;
    logic [31:0] entry_cnt;
  } ahv_out_t;

  // Hand-over from the parser to the output register.
  typedef struct packed {
    logic     load;
    ahv_out_t res;
  } ahv_res_t;

  // Expected magic byte for positions 0 to 2.
  function automatic logic [7:0] ahv_magic(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = MAGIC_B0;
      2'd1:    m = MAGIC_B1;
      default: m = MAGIC_B2;
    endcase
    return m;
  endfunction

  // One reflected CRC-32 byte update, eight bit steps unrolled.
  function automatic logic [31:0] ahv_crc_byte(input logic [31:0] c,
                                               input logic [7:0]  b);
    logic [31:0] x;
    x = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      x = (x >> 1) ^ (x[0] ? CRC_POLY : 32'h0);
    end
    return x;
  endfunction

endpackage

@@ hw/rtl/ahv_in_stage.sv @@
// ----------------------------------------------------------------------------
// Archive header validator input register
// Holds one incoming byte until the parser takes it.
// ----------------------------------------------------------------------------
module ahv_in_stage
  import ahv_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  ahv_in_t in_data,
  input  logic    take,
  output logic    item_vld,
  output ahv_in_t item
);

  logic    vld_r;
  ahv_in_t data_r;

  // The register is free when empty or when its item leaves this cycle.
  assign in_stall = vld_r & ~take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data_r <= in_data;
    end
  end

  assign item_vld = vld_r;
  assign item     = data_r;

endmodule

@@ hw/rtl/ahv_parse.sv @@
// ----------------------------------------------------------------------------
// Archive header validator parser
// Tracks header position, checks the magic, runs the CRC and builds results.
// ----------------------------------------------------------------------------
module ahv_parse
  import ahv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     item_vld,
  input  ahv_in_t  item,
  input  logic     out_free,
  output logic     take,
  output ahv_res_t res
);

  ahv_pos_t    pos_r, pos_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic        magic_bad_r, magic_bad_nxt;
  logic [31:0] off_r, off_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] scrc_r, scrc_nxt;

  logic        last;
  logic        emit;
  logic [1:0]  lane_off, lane_cnt, lane_scrc;
  logic [31:0] scrc_full;
  ahv_status_t status;

  assign lane_off  = 2'(pos_r - OFF_BASE);
  assign lane_cnt  = 2'(pos_r - CNT_BASE);
  assign lane_scrc = 2'(pos_r - SCRC_BASE);
  assign scrc_full = {item.data_byte, scrc_r[23:0]};

  assign last = (pos_r >= HDR_LAST_POS);
  assign emit = last | item.stream_end;
  // An item that produces no result never waits for the output register.
  assign take = item_vld & (~emit | out_free);

  always_comb begin
    magic_bad_nxt = magic_bad_r;
    if (pos_r < MAGIC_LEN && item.data_byte != ahv_magic(pos_r[1:0])) begin
      magic_bad_nxt = 1'b1;
    end

    crc_nxt = crc_r;
    if (pos_r < CRC_SPAN) begin
      crc_nxt = ahv_crc_byte(crc_r, item.data_byte);
    end

    off_nxt  = off_r;
    cnt_nxt  = cnt_r;
    scrc_nxt = scrc_r;
    if (pos_r >= OFF_BASE && pos_r < CNT_BASE) begin
      off_nxt[8*lane_off +: 8] = item.data_byte;
    end else if (pos_r >= CNT_BASE && pos_r < SCRC_BASE) begin
      cnt_nxt[8*lane_cnt +: 8] = item.data_byte;
    end else if (pos_r >= SCRC_BASE && pos_r <= HDR_LAST_POS) begin
      scrc_nxt[8*lane_scrc +: 8] = item.data_byte;
    end

    pos_nxt = pos_r + 5'd1;

    if (!last) begin
      status = ST_FORMAT;
    end else if (magic_bad_r) begin
      status = ST_FORMAT;
    end else if (~crc_r != scrc_full) begin
      status = ST_CRC;
    end else begin
      status = ST_OK;
    end

    res.load       = take & emit;
    res.res.status = status;
    if (status == ST_FORMAT) begin
      res.res.idx_ofs   = 32'h0;
      res.res.entry_cnt = 32'h0;
    end else begin
      res.res.idx_ofs   = off_r;
      res.res.entry_cnt = cnt_r;
    end
  end

  // Control state: position, CRC and magic flag restart after each result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      crc_r       <= CRC_INIT;
      magic_bad_r <= 1'b0;
    end else if (take) begin
      if (emit) begin
        pos_r       <= '0;
        crc_r       <= CRC_INIT;
        magic_bad_r <= 1'b0;
      end else begin
        pos_r       <= pos_nxt;
        crc_r       <= crc_nxt;
        magic_bad_r <= magic_bad_nxt;
      end
    end
  end

  // Every capture byte is rewritten before it is used, so no clearing.
  always_ff @(posedge clk) begin
    if (take) begin
      off_r  <= off_nxt;
      cnt_r  <= cnt_nxt;
      scrc_r <= scrc_nxt;
    end
  end

endmodule

@@ hw/rtl/ahv_out_stage.sv @@
// ----------------------------------------------------------------------------
// Archive header validator output register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module ahv_out_stage
  import ahv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  ahv_res_t res,
  output logic     out_free,
  output logic     out_valid,
  input  logic     out_stall,
  output ahv_out_t out_data
);

  logic     vld_r, vld_nxt;
  ahv_out_t data_r;

  assign out_free = ~vld_r | ~out_stall;

  always_comb begin
    if (res.load) begin
      vld_nxt = 1'b1;
    end else begin
      vld_nxt = vld_r & out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      data_r <= res.res;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

@@ hw/rtl/archive_header_validator_unit.sv @@
// Path: a transferred byte is held in the input register until the parser takes it;
// if it ends a header, its result is loaded into the output register behind out_valid.
// Throughput: one byte per cycle; only a byte that ends a header waits on a stalled result.
// Reset (rst_n low, synchronous): input and output registers are emptied, the byte
// position returns to zero, the CRC register to all ones and the magic flag clears.
// ----------------------------------------------------------------------------
// Archive header validator
// Checks an 18-byte archive header streamed one byte per transfer and reports
// its status with the index offset and file count.
// ----------------------------------------------------------------------------
module archive_header_validator_unit
  import ahv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ahv_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output ahv_out_t out_data
);

  // The pipeline is three short parts: an input register, the parser with its
  // header state, and an output register. The parser only takes a byte that
  // completes a header when the output register can accept the result, so a
  // waiting result never blocks bytes that produce none.

  logic     take;
  logic     item_vld;
  ahv_in_t  item;
  logic     out_free;
  ahv_res_t res;

  ahv_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .take     (take),
    .item_vld (item_vld),
    .item     (item)
  );

  // The parser holds the position, running CRC, magic flag and the captured
  // little-endian words. On the last header byte, or on an early end of
  // stream, it hands one result to the output register and restarts.
  ahv_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (item_vld),
    .item     (item),
    .out_free (out_free),
    .take     (take),
    .res      (res)
  );

  ahv_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // A format error never carries captured fields.
  a_format_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FORMAT
      |-> out_data.idx_ofs == 32'h0 && out_data.entry_cnt == 32'h0)
    else $error("format error result carries non-zero fields");

  // A result handed over by the parser appears on the output next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    res.load |=> out_valid)
    else $error("loaded result not presented");

  // A held byte is always taken while the output register is empty.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld && !out_valid |-> take)
    else $error("parser stalled with an empty output register");

  // The parser never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> !res.load)
    else $error("waiting result overwritten");
`endif

endmodule

@@ tb/archive_header_validator_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Archive header validator testbench
// Streams whole, corrupted, truncated and noisy 18-byte headers into the
// validator with random bursts and output back-pressure. A local parser
// predicts each status with its offset and count, and a checker compares
// every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module archive_header_validator_unit_tb;
  import ahv_pkg::*;

  // Clock, reset and the two channels of the block.
  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  ahv_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ahv_out_t out_data;

  archive_header_validator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The three magic bytes in header order.
  localparam logic [7:0] MAGIC_SEQ [3] = '{MAGIC_B0, MAGIC_B1, MAGIC_B2};

  // Shadow of the parser state, advanced once for every accepted byte.
  int unsigned hdr_pos;
  logic [31:0] crc_acc;
  logic        magic_bad;
  logic [31:0] offset_acc;
  logic [31:0] count_acc;
  logic [31:0] scrc_acc;

  // Predicted results, oldest first, and the failure bookkeeping.
  ahv_out_t    pending_status_q [$];
  int unsigned mismatch_count = 0;

  // Sender bookkeeping: bytes left in the current burst and bytes sent.
  int unsigned burst_left = 0;
  int unsigned bytes_sent = 0;

  // Working buffer for one header under construction.
  logic [7:0] hdr_buf [18];

  // Receiver back-pressure pattern generator.
  logic [5:0]  stall_tick = '0;
  logic [1:0]  stall_mode = '0;
  logic [15:0] stall_pat = '0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Reflected CRC-32, one input bit at a time: the feedback bit is the low
  // bit of the register exclusive-ORed with the next data bit.
  function automatic logic [31:0] crc32_update(input logic [31:0] crc,
                                               input logic [7:0]  b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  task automatic clear_parser();
    hdr_pos    = 0;
    crc_acc    = CRC_INIT;
    magic_bad  = 1'b0;
    offset_acc = '0;
    count_acc  = '0;
    scrc_acc   = '0;
  endtask

  // Advances the shadow parser by one accepted byte and queues the status
  // that the byte produces, if any.
  task automatic absorb_byte(input ahv_in_t it);
    ahv_out_t res;
    logic     fire;
    fire = 1'b0;
    res  = '0;
    if (hdr_pos < MAGIC_LEN && it.data_byte != MAGIC_SEQ[hdr_pos]) magic_bad = 1'b1;
    if (hdr_pos < CRC_SPAN) crc_acc = crc32_update(crc_acc, it.data_byte);
    if (hdr_pos >= OFF_BASE && hdr_pos < CNT_BASE)
      offset_acc[8*(hdr_pos - OFF_BASE) +: 8] = it.data_byte;
    else if (hdr_pos >= CNT_BASE && hdr_pos < SCRC_BASE)
      count_acc[8*(hdr_pos - CNT_BASE) +: 8] = it.data_byte;
    else if (hdr_pos >= SCRC_BASE)
      scrc_acc[8*(hdr_pos - SCRC_BASE) +: 8] = it.data_byte;

    if (hdr_pos >= HDR_LAST_POS) begin
      // A complete header reports whether or not the stream ends here.
      fire = 1'b1;
      if (magic_bad)
        res.status = ST_FORMAT;
      else if (~crc_acc != scrc_acc)
        res.status = ST_CRC;
      else
        res.status = ST_OK;
    end else if (it.stream_end) begin
      // The stream has run out before the header was complete.
      fire = 1'b1;
      res.status = ST_FORMAT;
    end else begin
      hdr_pos++;
    end

    if (fire) begin
      // Format errors carry zero fields; the other outcomes carry the captures.
      if (res.status != ST_FORMAT) begin
        res.idx_ofs   = offset_acc;
        res.entry_cnt = count_acc;
      end
      pending_status_q.push_back(res);
      clear_parser();
    end
  endtask

  // Sends one byte. Between bursts of random length the sender drops valid
  // for a short random gap; now and then a long burst gives a stretch without gaps.
  // The payload is held steady until the transfer has taken place.
  task automatic send_byte(input logic [7:0] b, input logic last);
    ahv_in_t it;
    int unsigned gap;
    it.data_byte  = b;
    it.stream_end = last;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90)
                                               : $urandom_range(1, 10);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_byte(it);
    burst_left--;
    bytes_sent++;
  endtask

  // Builds a well-formed header: magic, three random spare bytes, the given
  // offset and count, and the CRC of bytes 0 to 13 in the trailing four.
  task automatic make_header(input logic [31:0] offset, input logic [31:0] count);
    logic [31:0] c;
    for (int k = 0; k < 3; k++) hdr_buf[k] = MAGIC_SEQ[k];
    for (int k = 3; k < 6; k++) hdr_buf[k] = 8'($urandom);
    for (int k = 0; k < 4; k++) begin
      hdr_buf[OFF_BASE + k] = offset[8*k +: 8];
      hdr_buf[CNT_BASE + k] = count[8*k +: 8];
    end
    c = CRC_INIT;
    for (int k = 0; k < CRC_SPAN; k++) c = crc32_update(c, hdr_buf[k]);
    c = ~c;
    for (int k = 0; k < 4; k++) hdr_buf[SCRC_BASE + k] = c[8*k +: 8];
  endtask

  // Sends the buffer. With cut_at below 17 the stream ends at that byte;
  // otherwise the last byte carries end_last as its end-of-stream flag.
  task automatic send_header(input int unsigned cut_at, input logic end_last);
    for (int unsigned k = 0; k <= HDR_LAST_POS; k++) begin
      if (k == cut_at && k < HDR_LAST_POS) begin
        send_byte(hdr_buf[k], 1'b1);
        return;
      end
      send_byte(hdr_buf[k], (k == HDR_LAST_POS) ? end_last : 1'b0);
    end
  endtask

  // Good headers, with the field extremes and both end flags on the last byte.
  task automatic test_good_headers();
    make_header(32'h0000_0000, 32'hFFFF_FFFF);
    send_header(HDR_LAST_POS, 1'b1);
    make_header(32'hFFFF_FFFF, 32'h0000_0000);
    send_header(HDR_LAST_POS, 1'b0);
  endtask

  // A wrong magic byte wins over a CRC mismatch and zeroes the fields.
  task automatic test_bad_magic();
    make_header(32'h1234_5678, 32'h9ABC_DEF0);
    hdr_buf[1] = 8'h00;
    send_header(HDR_LAST_POS, 1'b0);
  endtask

  task automatic test_crc_mismatch();
    make_header(32'hFFFF_FFFF, 32'h0000_0001);
    hdr_buf[SCRC_BASE + 3] = hdr_buf[SCRC_BASE + 3] ^ 8'h80;
    send_header(HDR_LAST_POS, 1'b0);
  endtask

  // Streams that end on the very first byte and on the byte before the last.
  task automatic test_short_headers();
    make_header(32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_header(0, 1'b0);
    make_header(32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_header(HDR_LAST_POS - 1, 1'b0);
  endtask

  // Mostly well-formed headers with random content, plus corrupted CRCs,
  // corrupted magic, truncations and stretches of raw noise. After noise the
  // stream is closed off so that the next header starts at position zero.
  task automatic test_random_stream(input int unsigned n_bytes);
    int unsigned sel;
    int unsigned idx;
    int unsigned n;
    int unsigned stop;
    stop = bytes_sent + n_bytes;
    while (bytes_sent < stop) begin
      sel = $urandom_range(0, 99);
      make_header($urandom, $urandom);
      if (sel < 55) begin
        send_header(HDR_LAST_POS, 1'($urandom));
      end else if (sel < 67) begin
        idx = SCRC_BASE + $urandom_range(0, 3);
        hdr_buf[idx] = hdr_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
        send_header(HDR_LAST_POS, 1'($urandom));
      end else if (sel < 79) begin
        idx = $urandom_range(0, MAGIC_LEN - 1);
        hdr_buf[idx] = hdr_buf[idx] ^ 8'($urandom_range(1, 255));
        send_header(HDR_LAST_POS, 1'($urandom));
      end else if (sel < 89) begin
        send_header($urandom_range(0, HDR_LAST_POS - 1), 1'b0);
      end else begin
        n = $urandom_range(1, 24);
        repeat (n) send_byte(8'($urandom), ($urandom_range(0, 15) == 0));
        if (hdr_pos != 0) send_byte(8'($urandom), 1'b1);
      end
    end
  endtask

  // Receiver back-pressure: each time the 6-bit tick counter wraps, a new mode and
  // pattern are chosen, ranging from no stall at all to long runs of stall.
  always @(negedge clk) begin
    stall_tick <= stall_tick + 6'd1;
    if (stall_tick == '0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      stall_pat  <= 16'($urandom);
    end else begin
      stall_pat <= {stall_pat[0], stall_pat[15:1]};
    end
    case (stall_mode)
      2'd1:    out_stall <= stall_pat[0];
      2'd2:    out_stall <= stall_pat[0] | stall_pat[1];
      2'd3:    out_stall <= stall_pat[0] & stall_pat[3];
      default: out_stall <= 1'b0;
    endcase
  end

  // Result checker. Each result transfer is compared field by field with the
  // oldest prediction; a transfer with nothing predicted is a failure too.
  always @(posedge clk) begin
    ahv_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_status_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d offset %h count %h",
                   out_data.status, out_data.idx_ofs, out_data.entry_cnt);
      end else begin
        want = pending_status_q.pop_front();
        if (out_data.status !== want.status ||
            out_data.idx_ofs !== want.idx_ofs ||
            out_data.entry_cnt !== want.entry_cnt) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: expected status %0d offset %h count %h,",
                      " got status %0d offset %h count %h"},
                     want.status, want.idx_ofs, want.entry_cnt,
                     out_data.status, out_data.idx_ofs, out_data.entry_cnt);
        end
      end
    end
  end

  // Main sequence: reset, the directed tests, the random stream, then drain.
  initial begin
    int unsigned waited;
    clear_parser();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_good_headers();
    test_bad_magic();
    test_crc_mismatch();
    test_short_headers();
    test_random_stream(1100);

    @(negedge clk);
    in_valid <= 1'b0;

    // Results trail their last byte through the input and output registers plus any receiver stall.
    waited = 0;
    while (pending_status_q.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (pending_status_q.size() != 0) begin
      mismatch_count += pending_status_q.size();
      $display("%0d predicted results never arrived", pending_status_q.size());
    end

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
